### sv/hhfl_pkg.sv
package hhfl_pkg;

   localparam int OFFSET_BITS   = 32;
   localparam int MAX_TAG_LEN   = 4096;
   localparam int TAG_LEN_BITS  = $clog2(MAX_TAG_LEN + 1);

   localparam int KIND_COUNT    = 5;
   localparam int KIND_HEAD     = 0;
   localparam int KIND_END_HEAD = 1;
   localparam int KIND_TITLE    = 2;
   localparam int KIND_END_TITLE = 3;
   localparam int KIND_META     = 4;

   localparam int TITLE_SKIP       = 7;
   localparam int SCAN_FROM        = 6;
   localparam int NAME_KEY_LEN     = 6;
   localparam int CONTENT_KEY_LEN  = 9;
   localparam int NAME_PROG_BITS   = $clog2(NAME_KEY_LEN + 1);
   localparam int CONTENT_PROG_BITS = $clog2(CONTENT_KEY_LEN + 1);

   // scan flag bits
   localparam int SCAN_KEY_FOUND   = 0;
   localparam int SCAN_RUN_END     = 1;
   localparam int SCAN_QUOTE_FOUND = 1;

   localparam logic FIELD_TITLE = 1'b0;
   localparam logic FIELD_META  = 1'b1;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;

   localparam int NAME_LEN_BITS  = 13;
   localparam int REQ_TDATA_BITS = 8;
   localparam int RSP_PAYLOAD_BITS = 3 * OFFSET_BITS + NAME_LEN_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_PAYLOAD_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic                     field_kind;
      logic [OFFSET_BITS-1:0]   value_start;
      logic [OFFSET_BITS-1:0]   value_end;
      logic [OFFSET_BITS-1:0]   name_start;
      logic [NAME_LEN_BITS-1:0] name_length;
   } hhfl_result_type;

   function automatic logic is_alnum(input logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] b);
      return (b >= "a" && b <= "z") ? b - 8'd32 : b;
   endfunction

   function automatic logic [2:0] kind_len(input logic [2:0] kind);
      logic [2:0] len;
      case (kind)
         3'(KIND_HEAD):      len = 3'd4;
         3'(KIND_END_HEAD):  len = 3'd5;
         3'(KIND_TITLE):     len = 3'd5;
         3'(KIND_END_TITLE): len = 3'd6;
         3'(KIND_META):      len = 3'd4;
         default:            len = 3'd0;
      endcase
      return len;
   endfunction

   // tag name text, padded with blanks to six characters
   function automatic logic [7:0] kind_char(input logic [2:0] kind, input logic [2:0] pos);
      logic [47:0] text;
      logic [7:0]  c;
      case (kind)
         3'(KIND_HEAD):      text = "HEAD  ";
         3'(KIND_END_HEAD):  text = "/HEAD ";
         3'(KIND_TITLE):     text = "TITLE ";
         3'(KIND_END_TITLE): text = "/TITLE";
         3'(KIND_META):      text = "META  ";
         default:            text = "      ";
      endcase
      case (pos)
         3'd0:    c = text[47:40];
         3'd1:    c = text[39:32];
         3'd2:    c = text[31:24];
         3'd3:    c = text[23:16];
         3'd4:    c = text[15:8];
         3'd5:    c = text[7:0];
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] name_key_char(input logic [NAME_PROG_BITS-1:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = "N";
         3'd1:    c = "A";
         3'd2:    c = "M";
         3'd3:    c = "E";
         3'd4:    c = "=";
         3'd5:    c = CHAR_QUOTE;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] content_key_char(input logic [CONTENT_PROG_BITS-1:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = "C";
         4'd1:    c = "O";
         4'd2:    c = "N";
         4'd3:    c = "T";
         4'd4:    c = "E";
         4'd5:    c = "N";
         4'd6:    c = "T";
         4'd7:    c = "=";
         4'd8:    c = CHAR_QUOTE;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### sv/hhfl_core.sv
module hhfl_core
   import hhfl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      data_byte,
   input  logic            doc_start,
   output logic            emit,
   output hhfl_result_type result
);

   logic                          head_open_ff, head_open_in;
   logic                          parse_finished_ff, parse_finished_in;
   logic                          inside_tag_ff, inside_tag_in;
   logic [TAG_LEN_BITS-1:0]       tag_length_ff, tag_length_in;
   logic [OFFSET_BITS-1:0]        tag_start_offset_ff, tag_start_offset_in;
   logic [OFFSET_BITS-1:0]        byte_offset_ff, byte_offset_in;
   logic [OFFSET_BITS-1:0]        title_value_start_ff, title_value_start_in;
   logic                          title_opener_seen_ff, title_opener_seen_in;
   logic [KIND_COUNT-1:0]         tag_name_alive_ff, tag_name_alive_in;
   logic [NAME_PROG_BITS-1:0]     name_key_progress_ff, name_key_progress_in;
   logic [CONTENT_PROG_BITS-1:0]  content_key_progress_ff, content_key_progress_in;
   logic [TAG_LEN_BITS-1:0]       name_value_offset_ff, name_value_offset_in;
   logic [TAG_LEN_BITS-1:0]       name_run_length_ff, name_run_length_in;
   logic [1:0]                    name_scan_flags_ff, name_scan_flags_in;
   logic [TAG_LEN_BITS-1:0]       content_value_offset_ff, content_value_offset_in;
   logic [TAG_LEN_BITS-1:0]       closing_quote_offset_ff, closing_quote_offset_in;
   logic [1:0]                    content_scan_flags_ff, content_scan_flags_in;

   logic [OFFSET_BITS-1:0]  here;
   logic [TAG_LEN_BITS-1:0] idx;
   logic [OFFSET_BITS-1:0]  title_diff;

   always_comb begin
      // doc_start wipes everything before the byte is looked at
      head_open_in            = doc_start ? 1'b0 : head_open_ff;
      parse_finished_in       = doc_start ? 1'b0 : parse_finished_ff;
      inside_tag_in           = doc_start ? 1'b0 : inside_tag_ff;
      tag_start_offset_in     = doc_start ? '0 : tag_start_offset_ff;
      title_value_start_in    = doc_start ? '0 : title_value_start_ff;
      title_opener_seen_in    = doc_start ? 1'b0 : title_opener_seen_ff;
      tag_length_in           = doc_start ? '0 : tag_length_ff;
      tag_name_alive_in       = doc_start ? '1 : tag_name_alive_ff;
      name_key_progress_in    = doc_start ? '0 : name_key_progress_ff;
      content_key_progress_in = doc_start ? '0 : content_key_progress_ff;
      name_value_offset_in    = doc_start ? '0 : name_value_offset_ff;
      name_run_length_in      = doc_start ? '0 : name_run_length_ff;
      name_scan_flags_in      = doc_start ? '0 : name_scan_flags_ff;
      content_value_offset_in = doc_start ? '0 : content_value_offset_ff;
      closing_quote_offset_in = doc_start ? '0 : closing_quote_offset_ff;
      content_scan_flags_in   = doc_start ? '0 : content_scan_flags_ff;

      here           = doc_start ? '0 : byte_offset_ff;
      byte_offset_in = here + 1'b1;
      idx            = '0;
      title_diff     = '0;

      emit               = 1'b0;
      result.field_kind  = FIELD_TITLE;
      result.value_start = '0;
      result.value_end   = '0;
      result.name_start  = '0;
      result.name_length = '0;

      if (!parse_finished_in && (inside_tag_in || data_byte == CHAR_LT)) begin
         if (!inside_tag_in) begin
            inside_tag_in           = 1'b1;
            tag_start_offset_in     = here;
            tag_length_in           = '0;
            tag_name_alive_in       = '1;
            name_key_progress_in    = '0;
            content_key_progress_in = '0;
            name_value_offset_in    = '0;
            name_run_length_in      = '0;
            name_scan_flags_in      = '0;
            content_value_offset_in = '0;
            closing_quote_offset_in = '0;
            content_scan_flags_in   = '0;
         end
         idx = tag_length_in;

         // tag name matchers, one per known name
         for (int k = 0; k < KIND_COUNT; k++) begin
            if (idx >= TAG_LEN_BITS'(1) && idx <= TAG_LEN_BITS'(kind_len(3'(k)))) begin
               if (to_upper(data_byte) != kind_char(3'(k), 3'(idx - TAG_LEN_BITS'(1))))
                  tag_name_alive_in[k] = 1'b0;
            end else if (idx == TAG_LEN_BITS'(kind_len(3'(k))) + TAG_LEN_BITS'(1)
                         && is_alnum(data_byte)) begin
               tag_name_alive_in[k] = 1'b0;
            end
         end

         if (idx >= TAG_LEN_BITS'(SCAN_FROM)) begin
            // NAME=" search, then the alphanumeric run after it
            if (!name_scan_flags_in[SCAN_KEY_FOUND]) begin
               if (data_byte == name_key_char(name_key_progress_in))
                  name_key_progress_in = name_key_progress_in + 1'b1;
               else if (data_byte == name_key_char('0))
                  name_key_progress_in = NAME_PROG_BITS'(1);
               else
                  name_key_progress_in = '0;
               if (name_key_progress_in == NAME_PROG_BITS'(NAME_KEY_LEN)) begin
                  name_scan_flags_in[SCAN_KEY_FOUND] = 1'b1;
                  name_value_offset_in = idx + 1'b1;
                  name_run_length_in   = '0;
               end
            end else if (!name_scan_flags_in[SCAN_RUN_END]) begin
               if (is_alnum(data_byte))
                  name_run_length_in = name_run_length_in + 1'b1;
               else
                  name_scan_flags_in[SCAN_RUN_END] = 1'b1;
            end

            // CONTENT=" search, then the closing quote
            if (!content_scan_flags_in[SCAN_KEY_FOUND]) begin
               if (data_byte == content_key_char(content_key_progress_in))
                  content_key_progress_in = content_key_progress_in + 1'b1;
               else if (data_byte == content_key_char('0))
                  content_key_progress_in = CONTENT_PROG_BITS'(1);
               else
                  content_key_progress_in = '0;
               if (content_key_progress_in == CONTENT_PROG_BITS'(CONTENT_KEY_LEN)) begin
                  content_scan_flags_in[SCAN_KEY_FOUND] = 1'b1;
                  content_value_offset_in = idx + 1'b1;
               end
            end else if (!content_scan_flags_in[SCAN_QUOTE_FOUND]) begin
               if (data_byte == CHAR_QUOTE) begin
                  content_scan_flags_in[SCAN_QUOTE_FOUND] = 1'b1;
                  closing_quote_offset_in = idx;
               end
            end
         end

         tag_length_in = idx + 1'b1;

         // tag closes on '>' or when cut at the length limit
         if (data_byte == CHAR_GT || tag_length_in >= TAG_LEN_BITS'(MAX_TAG_LEN)) begin
            inside_tag_in = 1'b0;
            if (!head_open_in) begin
               if (tag_name_alive_in[KIND_HEAD])
                  head_open_in = 1'b1;
            end else if (tag_name_alive_in[KIND_END_HEAD]) begin
               parse_finished_in = 1'b1;
            end else begin
               if (tag_name_alive_in[KIND_TITLE]) begin
                  title_value_start_in = tag_start_offset_in + OFFSET_BITS'(TITLE_SKIP);
                  title_opener_seen_in = 1'b1;
               end
               title_diff = tag_start_offset_in - 1'b1 - title_value_start_in;
               if (title_opener_seen_in && tag_name_alive_in[KIND_END_TITLE]
                   && title_diff != '0 && !title_diff[OFFSET_BITS-1]) begin
                  emit               = 1'b1;
                  result.field_kind  = FIELD_TITLE;
                  result.value_start = title_value_start_in;
                  result.value_end   = tag_start_offset_in - 1'b1;
               end else if (tag_name_alive_in[KIND_META]
                            && name_scan_flags_in[SCAN_KEY_FOUND]
                            && content_scan_flags_in == 2'b11
                            && name_run_length_in != '0) begin
                  emit               = 1'b1;
                  result.field_kind  = FIELD_META;
                  result.value_start = tag_start_offset_in
                                       + OFFSET_BITS'(content_value_offset_in);
                  result.value_end   = tag_start_offset_in
                                       + OFFSET_BITS'(closing_quote_offset_in) - 1'b1;
                  result.name_start  = tag_start_offset_in
                                       + OFFSET_BITS'(name_value_offset_in);
                  result.name_length = NAME_LEN_BITS'(name_run_length_in);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_open_ff            <= 1'b0;
         parse_finished_ff       <= 1'b0;
         inside_tag_ff           <= 1'b0;
         tag_length_ff           <= '0;
         tag_start_offset_ff     <= '0;
         byte_offset_ff          <= '0;
         title_value_start_ff    <= '0;
         title_opener_seen_ff    <= 1'b0;
         tag_name_alive_ff       <= '1;
         name_key_progress_ff    <= '0;
         content_key_progress_ff <= '0;
         name_value_offset_ff    <= '0;
         name_run_length_ff      <= '0;
         name_scan_flags_ff      <= '0;
         content_value_offset_ff <= '0;
         closing_quote_offset_ff <= '0;
         content_scan_flags_ff   <= '0;
      end else if (step) begin
         head_open_ff            <= head_open_in;
         parse_finished_ff       <= parse_finished_in;
         inside_tag_ff           <= inside_tag_in;
         tag_length_ff           <= tag_length_in;
         tag_start_offset_ff     <= tag_start_offset_in;
         byte_offset_ff          <= byte_offset_in;
         title_value_start_ff    <= title_value_start_in;
         title_opener_seen_ff    <= title_opener_seen_in;
         tag_name_alive_ff       <= tag_name_alive_in;
         name_key_progress_ff    <= name_key_progress_in;
         content_key_progress_ff <= content_key_progress_in;
         name_value_offset_ff    <= name_value_offset_in;
         name_run_length_ff      <= name_run_length_in;
         name_scan_flags_ff      <= name_scan_flags_in;
         content_value_offset_ff <= content_value_offset_in;
         closing_quote_offset_ff <= closing_quote_offset_in;
         content_scan_flags_ff   <= content_scan_flags_in;
      end
   end

endmodule

### sv/html_head_field_locator_unit.sv
// Channel  | Dir | Ports                                        | Carries
// ---------+-----+----------------------------------------------+------------------------------
// request  | in  | req_tvalid, req_tready, req_tdata, req_tuser | doc byte; tuser = doc_start
// response | out | rsp_tvalid, rsp_tready, rsp_tdata, rsp_tuser | field span; tuser = field_kind
//
// One byte per cycle sustained while rsp is not stalled: a request is registered on
// acceptance, run through the parse core once the output register is free, and its
// response (if any) is captured in the output register, from which it shows on rsp.
// Reset is synchronous, active high, and clears all parse state and both
// valid flags. A stalled response holds the output register and the core; a request
// is still taken as long as the byte already held can move on in the same cycle.
module html_head_field_locator_unit
   import hhfl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,   // [7:0] data_byte
   input  logic                      req_tuser,   // [0] doc_start
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,   // value_start, value_end, name_start,
                                                  // name_length, zero fill
   output logic                      rsp_tuser    // [0] field_kind
);

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_doc_ff;
   logic            out_valid_ff;
   hhfl_result_type out_result_ff;

   logic            out_free;
   logic            core_step;
   logic            core_emit;
   hhfl_result_type core_result;

   // the output register frees up when empty or being drained this cycle
   assign out_free   = !out_valid_ff || rsp_tready;
   assign core_step  = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   hhfl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (core_step),
      .data_byte (in_byte_ff),
      .doc_start (in_doc_ff),
      .emit      (core_emit),
      .result    (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            in_valid_ff <= 1'b1;
         else if (core_step)
            in_valid_ff <= 1'b0;

         if (core_step)
            out_valid_ff <= core_emit;
         else if (rsp_tready)
            out_valid_ff <= 1'b0;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata[7:0];
         in_doc_ff  <= req_tuser;
      end
      if (core_step && core_emit)
         out_result_ff <= core_result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.field_kind;
   assign rsp_tdata  = {{(RSP_TDATA_BITS - RSP_PAYLOAD_BITS){1'b0}},
                        out_result_ff.name_length,
                        out_result_ff.name_start,
                        out_result_ff.value_end,
                        out_result_ff.value_start};

`ifndef SYNTHESIS
   // a result from the core always shows up on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      core_step && core_emit |=> rsp_tvalid)
      else $error("core result not registered");

   // core never overwrites a response that is still stalled
   assert property (@(posedge clock) disable iff (reset)
      !(out_valid_ff && !rsp_tready && core_step))
      else $error("core stepped over a stalled response");

   // an empty input stage must take a request
   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("empty input stage not ready");

   // title spans carry no name
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == FIELD_TITLE |->
         out_result_ff.name_length == '0 && out_result_ff.name_start == '0)
      else $error("title span with name fields");

   // meta spans always carry a non-empty name run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == FIELD_META |-> out_result_ff.name_length != '0)
      else $error("meta span with empty name");
`endif

endmodule

### sim/testbench.sv
module testbench;
   import hhfl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // how a directed document is checked
   typedef enum int {BY_MODEL, NO_SPAN, ONE_SPAN} check_mode_type;

   typedef struct {
      bit              fresh;     // raise doc_start on the first byte
      string           head;      // '~' stands for 8'h00, '^' for 8'hFF
      int              fill_len;
      logic [7:0]      fill;
      string           tail;
      check_mode_type  mode;
      hhfl_result_type want;      // used only for ONE_SPAN
   } doc_case_type;

   localparam int    HOLD_CYCLES = 300;
   localparam int    EAGER_BYTES = 400;
   localparam string NAME_KEY    = "NAME=\"";
   localparam string CONTENT_KEY = "CONTENT=\"";

   // indexed by KIND_HEAD .. KIND_META
   string tag_word [KIND_COUNT] = '{"HEAD", "/HEAD", "TITLE", "/TITLE", "META"};

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tuser;

   // spans the parser is expected to report, oldest first
   hhfl_result_type span_q [$];
   doc_case_type    doc_cases [$];
   logic [7:0]      doc_buf [$];

   int  mismatch_count = 0;
   int  title_spans    = 0;
   int  meta_spans     = 0;
   int  spans_due      = 0;
   int  bytes_sent     = 0;
   int  eager_left     = 0;
   int  send_calm      = 0;
   bit  backlog_request = 1'b0;

   // shadow copy of the parser state
   logic                   head_open_s, parse_done_s, in_tag_s, title_seen_s;
   logic [OFFSET_BITS-1:0] tag_at_s, byte_at_s, title_at_s;
   logic [KIND_COUNT-1:0]  alive_s;
   int                     tag_len_s, name_prog_s, content_prog_s;
   int                     name_off_s, name_run_s, content_off_s, quote_off_s;
   bit                     name_found_s, name_ended_s, content_found_s, quote_found_s;

   always #5 clock = ~clock;

   html_head_field_locator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // ---------------------------------------------------------------- predictor

   function automatic bit word_char(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic [7:0] fold_upper(logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   // substring search step: restart on the key's first letter only
   function automatic int key_advance(int prog, logic [7:0] c, string key);
      if (c == key[prog])
         return prog + 1;
      return (c == key[0]) ? 1 : 0;
   endfunction

   function automatic void start_tag_scan();
      tag_len_s       = 0;
      alive_s         = '1;
      name_prog_s     = 0;
      content_prog_s  = 0;
      name_off_s      = 0;
      name_run_s      = 0;
      content_off_s   = 0;
      quote_off_s     = 0;
      name_found_s    = 1'b0;
      name_ended_s    = 1'b0;
      content_found_s = 1'b0;
      quote_found_s   = 1'b0;
   endfunction

   function automatic void clear_parser();
      head_open_s  = 1'b0;
      parse_done_s = 1'b0;
      in_tag_s     = 1'b0;
      title_seen_s = 1'b0;
      tag_at_s     = '0;
      byte_at_s    = '0;
      title_at_s   = '0;
      start_tag_scan();
   endfunction

   // decide what a finished tag means; returns 1 with a span to report
   function automatic bit finish_tag(output hhfl_result_type span);
      logic [OFFSET_BITS-1:0] gap;
      span = '0;
      if (!head_open_s) begin
         if (alive_s[KIND_HEAD])
            head_open_s = 1'b1;
         return 1'b0;
      end
      if (alive_s[KIND_END_HEAD]) begin
         parse_done_s = 1'b1;
         return 1'b0;
      end
      if (alive_s[KIND_TITLE]) begin
         // value counted from the '<', attributes or not
         title_at_s   = tag_at_s + TITLE_SKIP;
         title_seen_s = 1'b1;
      end
      if (title_seen_s && alive_s[KIND_END_TITLE]) begin
         // title must hold at least two bytes; difference read as signed
         gap = tag_at_s - 1 - title_at_s;
         if (gap != 0 && !gap[OFFSET_BITS-1]) begin
            span.field_kind  = FIELD_TITLE;
            span.value_start = title_at_s;
            span.value_end   = tag_at_s - 1;
            return 1'b1;
         end
      end
      if (alive_s[KIND_META] && name_found_s && content_found_s && quote_found_s
          && name_run_s > 0) begin
         span.field_kind  = FIELD_META;
         span.value_start = tag_at_s + content_off_s;
         span.value_end   = tag_at_s + quote_off_s - 1;
         span.name_start  = tag_at_s + name_off_s;
         span.name_length = NAME_LEN_BITS'(name_run_s);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // advance the shadow parser by one document byte
   function automatic bit locate_fields(input logic [7:0] c, input bit fresh,
                                        output hhfl_result_type span);
      logic [OFFSET_BITS-1:0] here;
      int idx, len;
      span = '0;
      if (fresh)
         clear_parser();
      here      = byte_at_s;
      byte_at_s = byte_at_s + 1;
      if (parse_done_s)
         return 1'b0;
      if (!in_tag_s) begin
         if (c != CHAR_LT)
            return 1'b0;
         in_tag_s = 1'b1;
         tag_at_s = here;
         start_tag_scan();
      end
      idx = tag_len_s;
      for (int k = 0; k < KIND_COUNT; k++) begin
         len = tag_word[k].len();
         if (idx >= 1 && idx <= len) begin
            if (fold_upper(c) != tag_word[k][idx-1])
               alive_s[k] = 1'b0;
         end else if (idx == len + 1 && word_char(c)) begin
            alive_s[k] = 1'b0;
         end
      end
      if (idx >= SCAN_FROM) begin
         if (!name_found_s) begin
            name_prog_s = key_advance(name_prog_s, c, NAME_KEY);
            if (name_prog_s == NAME_KEY_LEN) begin
               name_found_s = 1'b1;
               name_off_s   = idx + 1;
               name_run_s   = 0;
            end
         end else if (!name_ended_s) begin
            if (word_char(c))
               name_run_s++;
            else
               name_ended_s = 1'b1;
         end
         if (!content_found_s) begin
            content_prog_s = key_advance(content_prog_s, c, CONTENT_KEY);
            if (content_prog_s == CONTENT_KEY_LEN) begin
               content_found_s = 1'b1;
               content_off_s   = idx + 1;
            end
         end else if (!quote_found_s) begin
            if (c == CHAR_QUOTE) begin
               quote_found_s = 1'b1;
               quote_off_s   = idx;
            end
         end
      end
      tag_len_s = idx + 1;
      // '>' or the length cap both end the tag
      if (c == CHAR_GT || tag_len_s >= MAX_TAG_LEN) begin
         in_tag_s = 1'b0;
         return finish_tag(span);
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------- pacing

   // mostly short gaps, a few long ones, and now and then a calm stretch
   function automatic int idle_cycles(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // response side backpressure; a backlog request holds tready low for a
   // long stretch while the sender keeps pushing, so the unit has to stall
   initial begin : rsp_pacer
      int gap;
      int calm;
      calm = 0;
      forever begin
         @(posedge clock);
         if (backlog_request) begin
            backlog_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = idle_cycles(calm);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- request side

   // offer one byte, wait for the handshake, then update the shadow parser
   task automatic push_byte(input logic [7:0] c, input bit fresh, input bit use_model);
      int              gap;
      bit              hit;
      hhfl_result_type span;
      if (eager_left > 0) begin
         eager_left--;
         gap = 0;
      end else begin
         gap = idle_cycles(send_calm);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= fresh;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      hit = locate_fields(c, fresh, span);
      if (hit && use_model) begin
         span_q.push_back(span);
         spans_due++;
      end
   endtask

   // stop offering until every pending span has come back
   task automatic drain_pause();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (span_q.size() != 0) @(posedge clock);
   endtask

   function automatic void load_text(string s);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (c == "~")
            c = 8'h00;
         else if (c == "^")
            c = 8'hFF;
         doc_buf.push_back(c);
      end
   endfunction

   task automatic add_case(bit fresh, string head, int fill_len, logic [7:0] fill,
                           string tail, check_mode_type mode, logic kind = FIELD_TITLE,
                           int vs = 0, int ve = 0, int ns = 0, int nl = 0);
      doc_case_type dc;
      dc.fresh    = fresh;
      dc.head     = head;
      dc.fill_len = fill_len;
      dc.fill     = fill;
      dc.tail     = tail;
      dc.mode     = mode;
      dc.want.field_kind  = kind;
      dc.want.value_start = vs;
      dc.want.value_end   = ve;
      dc.want.name_start  = ns;
      dc.want.name_length = NAME_LEN_BITS'(nl);
      doc_cases.push_back(dc);
   endtask

   task automatic run_case(doc_case_type dc);
      doc_buf.delete();
      load_text(dc.head);
      repeat (dc.fill_len) doc_buf.push_back(dc.fill);
      load_text(dc.tail);
      for (int i = 0; i < doc_buf.size(); i++) begin
         push_byte(doc_buf[i], dc.fresh && i == 0, dc.mode == BY_MODEL);
         if (i == 0 && dc.mode == ONE_SPAN)
            span_q.push_back(dc.want);
      end
   endtask

   // ---------------------------------------------------------------- random documents

   function automatic logic [7:0] flip_case(logic [7:0] c);
      if (c >= "a" && c <= "z")
         return c - 8'd32;
      if (c >= "A" && c <= "Z")
         return c + 8'd32;
      return c;
   endfunction

   function automatic void add_word(string s, bit mixed);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (mixed && $urandom_range(0, 1))
            c = flip_case(c);
         doc_buf.push_back(c);
      end
   endfunction

   function automatic void add_noise(int n);
      repeat (n) doc_buf.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void add_alnum(int n);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 61);
         if (r < 10)
            doc_buf.push_back(8'("0" + r));
         else if (r < 36)
            doc_buf.push_back(8'("A" + r - 10));
         else
            doc_buf.push_back(8'("a" + r - 36));
      end
   endfunction

   // printable text that cannot end a tag or a quoted value
   function automatic void add_plain(int n);
      logic [7:0] c;
      repeat (n) begin
         c = 8'($urandom_range(32, 126));
         if (c == CHAR_QUOTE || c == CHAR_GT || c == CHAR_LT)
            c = ".";
         doc_buf.push_back(c);
      end
   endfunction

   function automatic void add_title();
      add_word("<title", 1);
      if ($urandom_range(0, 2) == 0) begin
         add_word(" class=\"", 0);
         add_alnum($urandom_range(0, 4));
         add_word("\"", 0);
      end
      add_word(">", 0);
      add_plain($urandom_range(0, 8));
      if ($urandom_range(0, 9) != 0)
         add_word("</title>", 1);
   endfunction

   function automatic void add_name_attr();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         add_word("name=\"", 0);
      else if (pick == 1)
         add_word("NAME=", 0);
      else if (pick == 2)
         add_word("NNAME=\"", 0);
      else
         add_word(NAME_KEY, 0);
      add_alnum(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
      if ($urandom_range(0, 4) == 0)
         add_plain($urandom_range(1, 3));
      add_word("\"", 0);
   endfunction

   function automatic void add_content_attr();
      if ($urandom_range(0, 9) == 0)
         add_word("content=\"", 0);
      else
         add_word(CONTENT_KEY, 0);
      add_plain($urandom_range(0, 8));
      if ($urandom_range(0, 9) != 0)
         add_word("\"", 0);
   endfunction

   function automatic void add_meta();
      add_word("<meta ", 1);
      if ($urandom_range(0, 4) == 0)
         add_word("http-equiv=x ", 0);
      if ($urandom_range(0, 1)) begin
         add_name_attr();
         add_word(" ", 0);
         add_content_attr();
      end else begin
         add_content_attr();
         add_word(" ", 0);
         add_name_attr();
      end
      add_word(($urandom_range(0, 3) == 0) ? " />" : ">", 0);
   endfunction

   // mostly well-formed head sections, plus noise and broken tags
   function automatic void compose_doc();
      int pick;
      doc_buf.delete();
      add_noise($urandom_range(0, 4));
      pick = $urandom_range(0, 99);
      if (pick < 80)
         add_word("<head>", 1);
      else if (pick < 90)
         add_word("<head lang=x>", 1);
      else if (pick < 95)
         add_word("<header>", 1);
      repeat ($urandom_range(2, 7)) begin
         pick = $urandom_range(0, 99);
         if (pick < 42) begin
            add_meta();
         end else if (pick < 66) begin
            add_title();
         end else if (pick < 80) begin
            add_noise($urandom_range(1, 6));
         end else if (pick < 90) begin
            add_word("<", 0);
            add_plain($urandom_range(0, 6));
            add_word(">", 0);
         end else if (pick < 95) begin
            add_word("</title>", 1);
         end else begin
            add_word("</head>", 1);
         end
      end
   endfunction

   // ---------------------------------------------------------------- response check

   task automatic compare_field(string what, logic [OFFSET_BITS-1:0] want,
                                logic [OFFSET_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // rsp_tdata: value_start, value_end, name_start, name_length from bit 0 up
   always @(posedge clock) begin : span_check
      hhfl_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.field_kind  = rsp_tuser;
         got.value_start = rsp_tdata[OFFSET_BITS-1:0];
         got.value_end   = rsp_tdata[2*OFFSET_BITS-1:OFFSET_BITS];
         got.name_start  = rsp_tdata[3*OFFSET_BITS-1:2*OFFSET_BITS];
         got.name_length = rsp_tdata[3*OFFSET_BITS +: NAME_LEN_BITS];
         if (span_q.size() == 0) begin
            $display("%0t ns: span with nothing expected: kind %0d value %0d..%0d",
                     $time, got.field_kind, got.value_start, got.value_end);
            mismatch_count++;
         end else begin
            want = span_q.pop_front();
            compare_field("field_kind", OFFSET_BITS'(want.field_kind),
                          OFFSET_BITS'(got.field_kind));
            compare_field("value_start", want.value_start, got.value_start);
            compare_field("value_end", want.value_end, got.value_end);
            compare_field("name_start", want.name_start, got.name_start);
            compare_field("name_length", OFFSET_BITS'(want.name_length),
                          OFFSET_BITS'(got.name_length));
            if (want.field_kind == FIELD_TITLE)
               title_spans++;
            else
               meta_spans++;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      int random_docs, random_from, settle;
      bit fresh;

      clear_parser();

      // fresh, head, fill count, fill byte, tail, check, expected span
      add_case(0, "<head><title>ab</title>", 0, "x", "", ONE_SPAN, FIELD_TITLE, 13, 14);
      add_case(1, "<HEAD><TITLE>x</TITLE>", 0, "x", "", NO_SPAN);   // one-byte title
      add_case(1, "<head><title></title>", 0, "x", "", NO_SPAN);    // empty title
      add_case(1, "<head></title>", 0, "x", "", NO_SPAN);           // close w/o opener
      add_case(1, "<head><META NAME=\"ab\" CONTENT=\"xyz\">", 0, "x", "", ONE_SPAN,
               FIELD_META, 31, 33, 18, 2);
      add_case(1, "<head><META NAME=\"a\" CONTENT=\"\">", 0, "x", "", BY_MODEL);
      add_case(1, "<head><META NAME=\"\" CONTENT=\"v\">", 0, "x", "", NO_SPAN);
      add_case(1, "<head><meta name=\"a\" content=\"b\">", 0, "x", "", NO_SPAN);
      add_case(1, "<head></head><title>zz</title>", 0, "x", "", NO_SPAN);
      add_case(1, "<heads><title>ab</title>", 0, "x", "", NO_SPAN);
      add_case(1, "<head>~<title>a~b^</title>^", 0, "x", "", BY_MODEL);
      add_case(1, "<head><title lang=\"en\">abc</title>", 0, "x", "", BY_MODEL);
      // name run cut off by the tag length limit
      add_case(1, "<head><META CONTENT=\"v\" NAME=\"", 4100, "a", "", BY_MODEL);
      // closing quote never reached before the cut
      add_case(1, "<head><META NAME=\"ab\" CONTENT=\"", 4090, "z", "\">", BY_MODEL);
      add_case(1, "<head><title>", 300, "x", "</title>", ONE_SPAN, FIELD_TITLE, 13, 312);
      add_case(1, "<HeAd><TiTlE>q r</tItLe>", 0, "x", "", BY_MODEL);
      add_case(0, "<META NAME=\"k9\" CONTENT=\"w\">", 0, "x", "", BY_MODEL);
      add_case(1, "<head><META CONTENT=\"c1\" NAME=\"n1\" NAME=\"n2\" CONTENT=\"c2\">",
               0, "x", "", BY_MODEL);
      add_case(1, "<head><META NNAME=\"x-y\" CCONTENT=\"y\"><ti<tle>", 0, "x", "", BY_MODEL);
      add_case(1, "<head><META NAME=\"a", 0, "x", "", NO_SPAN);     // left open
      add_case(1, "<head><title>ok</title>", 0, "x", "", ONE_SPAN, FIELD_TITLE, 13, 14);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (doc_cases[n])
         run_case(doc_cases[n]);
      drain_pause();

      // random documents until enough bytes have gone through
      random_from = bytes_sent;
      random_docs = 0;
      while (bytes_sent - random_from < 900) begin
         compose_doc();
         if (random_docs == 3) begin
            backlog_request = 1'b1;
            eager_left      = EAGER_BYTES;
         end
         if (random_docs == 12)
            drain_pause();
         fresh = (random_docs == 0) || ($urandom_range(0, 9) != 0);
         for (int i = 0; i < doc_buf.size(); i++)
            push_byte(doc_buf[i], fresh && i == 0, 1'b1);
         random_docs++;
      end

      req_tvalid <= 1'b0;
      settle = 0;
      while (span_q.size() != 0 && settle < 5000) begin
         @(posedge clock);
         settle++;
      end
      repeat (64) @(posedge clock);
      if (span_q.size() != 0) begin
         $display("%0t ns: %0d expected spans never arrived", $time, span_q.size());
         mismatch_count += span_q.size();
      end

      $display("Sent %0d document bytes: %0d directed cases, %0d random documents.",
               bytes_sent, doc_cases.size(), random_docs);
      $display("Checked %0d title spans and %0d meta spans, incl. cut tags and stalls.",
               title_spans, meta_spans);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // hard stop in case a handshake never completes
   initial begin : watchdog
      #100_000_000;
      $display("%0t ns: run timed out", $time);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
sv/hhfl_pkg.sv
sv/hhfl_core.sv
sv/html_head_field_locator_unit.sv
sim/testbench.sv
